>>> rtl/core/ipdfs_pkg.sv
package ipdfs_pkg;

    localparam int FRAME_BITS_DEF = 48;
    localparam int FRAME_IN_W     = 48;
    localparam int REPEAT_W       = 16;
    localparam int SEG_W          = 16;
    localparam int TICK_W         = 20;
    localparam int POS_W          = 7;
    localparam int PHASE_W        = 3;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_HDR_MARK  = 3'd0;
    localparam logic [2:0] REG_HDR_SPACE = 3'd1;
    localparam logic [2:0] REG_BIT_MARK  = 3'd2;
    localparam logic [2:0] REG_ONE_SPACE = 3'd3;
    localparam logic [2:0] REG_ZERO_SPC  = 3'd4;
    localparam logic [2:0] REG_GAP       = 3'd5;

    localparam logic [SEG_W-1:0]  HDR_MARK_RST  = 16'd6820;
    localparam logic [SEG_W-1:0]  HDR_SPACE_RST = 16'd6820;
    localparam logic [SEG_W-1:0]  BIT_MARK_RST  = 16'd580;
    localparam logic [SEG_W-1:0]  ONE_SPACE_RST = 16'd1860;
    localparam logic [SEG_W-1:0]  ZERO_SPC_RST  = 16'd580;
    localparam logic [TICK_W-1:0] GAP_RST       = 20'd100000;

    typedef struct packed {
        logic [SEG_W-1:0]  header_mark_ticks;
        logic [SEG_W-1:0]  header_space_ticks;
        logic [SEG_W-1:0]  bit_mark_ticks;
        logic [SEG_W-1:0]  one_space_ticks;
        logic [SEG_W-1:0]  zero_space_ticks;
        logic [TICK_W-1:0] gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic ir_mark;
        logic busy_res;
        logic done_res;
    } res_t;

endpackage

>>> rtl/core/ir_pulse_distance_frame_sender.sv
// Channel   Dir  Handshake                  Contents
// s_*       in   s_tvalid / s_tready        tuser: op; tdata: frame_data, repeat_count
// m_*       out  m_tvalid / m_tready        tdata: ir_mark, busy_res; tlast: done_res
// APB       in   psel & penable & pwrite    timing registers, 4 bytes apart
//
// One item per cycle while s_tready is high: each transaction is resolved
// in the cycle it is accepted and its result is registered into the output stage.
// s_tready is high while the output stage is empty or being drained.
// Reset (rst_n low, async) returns the sequencer to idle and the timing
// registers to their default lengths; no clearing pass.
module ir_pulse_distance_frame_sender
    import ipdfs_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [63:0]        s_tdata,   // [47:0] frame_data, [63:48] repeat_count
    input  logic               s_tuser,   // [0] op

    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [0] ir_mark, [1] busy_res, [7:2] zero
    output logic               m_tlast,   // done_res

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic out_valid_reg;
    logic step;

    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    ipdfs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipdfs_seq #(
        .FRAME_BITS (FRAME_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .op           (s_tuser),
        .frame_data   (s_tdata[FRAME_IN_W-1:0]),
        .repeat_count (s_tdata[FRAME_IN_W +: REPEAT_W]),
        .cfg          (cfg),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, res_reg.busy_res, res_reg.ir_mark};
    assign m_tlast  = res_reg.done_res;

endmodule

>>> rtl/core/ipdfs_regs.sv
module ipdfs_regs
    import ipdfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_HDR_MARK:  cfg_next.header_mark_ticks  = pwdata[SEG_W-1:0];
                REG_HDR_SPACE: cfg_next.header_space_ticks = pwdata[SEG_W-1:0];
                REG_BIT_MARK:  cfg_next.bit_mark_ticks     = pwdata[SEG_W-1:0];
                REG_ONE_SPACE: cfg_next.one_space_ticks    = pwdata[SEG_W-1:0];
                REG_ZERO_SPC:  cfg_next.zero_space_ticks   = pwdata[SEG_W-1:0];
                REG_GAP:       cfg_next.gap_ticks          = pwdata[TICK_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HDR_MARK:  prdata = PDATA_W'(cfg_reg.header_mark_ticks);
            REG_HDR_SPACE: prdata = PDATA_W'(cfg_reg.header_space_ticks);
            REG_BIT_MARK:  prdata = PDATA_W'(cfg_reg.bit_mark_ticks);
            REG_ONE_SPACE: prdata = PDATA_W'(cfg_reg.one_space_ticks);
            REG_ZERO_SPC:  prdata = PDATA_W'(cfg_reg.zero_space_ticks);
            REG_GAP:       prdata = PDATA_W'(cfg_reg.gap_ticks);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_mark_ticks  <= HDR_MARK_RST;
            cfg_reg.header_space_ticks <= HDR_SPACE_RST;
            cfg_reg.bit_mark_ticks     <= BIT_MARK_RST;
            cfg_reg.one_space_ticks    <= ONE_SPACE_RST;
            cfg_reg.zero_space_ticks   <= ZERO_SPC_RST;
            cfg_reg.gap_ticks          <= GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/core/ipdfs_seq.sv
module ipdfs_seq
    import ipdfs_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  op,
    input  logic [FRAME_IN_W-1:0] frame_data,
    input  logic [REPEAT_W-1:0]   repeat_count,
    input  cfg_t                  cfg,
    output res_t                  res
);

    localparam int BYTE_COUNT = (FRAME_BITS + 7) / 8;
    localparam int WORD_BITS  = BYTE_COUNT * 8;
    localparam int DATA_BITS  = BYTE_COUNT * 16;

    localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR_MARK   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HDR_SPACE  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BIT_MARK   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_BIT_SPACE  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_FOOT_MARK  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_FOOT_SPACE = 3'd6;
    localparam logic [PHASE_W-1:0] PH_GAP        = 3'd7;

    localparam logic [POS_W:0] LAST_POS = (POS_W+1)'(DATA_BITS - 1);

    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_left_reg, tick_left_next;
    logic [POS_W-1:0]     bit_pos_reg, bit_pos_next;
    logic [WORD_BITS-1:0] frame_word_reg, frame_word_next;
    logic [REPEAT_W-1:0]  repeats_reg, repeats_next;

    logic [63:0]          word_pad;
    logic [63:0]          data_pad;
    logic [7:0]           cur_byte;
    logic                 cur_bit;
    logic                 mark_lvl;

    // byte select by pos[6:4], bit by pos[2:0], pos[3] picks the inverted copy
    always_comb
    begin
        word_pad = '0;
        word_pad[WORD_BITS-1:0] = frame_word_reg;
        data_pad = 64'(frame_data);
    end

    assign cur_byte = word_pad[{bit_pos_reg[6:4], 3'b000} +: 8];
    assign cur_bit  = cur_byte[bit_pos_reg[2:0]] ^ bit_pos_reg[3];
    assign mark_lvl = (phase_reg == PH_HDR_MARK) || (phase_reg == PH_BIT_MARK) ||
                      (phase_reg == PH_FOOT_MARK);

    always_comb
    begin
        phase_next      = phase_reg;
        tick_left_next  = tick_left_reg;
        bit_pos_next    = bit_pos_reg;
        frame_word_next = frame_word_reg;
        repeats_next    = repeats_reg;
        res             = '0;

        if (op)
        begin
            res.busy_res = 1'b1;
            if (phase_reg == PH_IDLE)
            begin
                frame_word_next = data_pad[WORD_BITS-1:0];
                repeats_next    = repeat_count;
                bit_pos_next    = '0;
                phase_next      = PH_HDR_MARK;
                tick_left_next  = TICK_W'(cfg.header_mark_ticks);
            end
            else
            begin
                res.ir_mark = mark_lvl;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            res.ir_mark  = mark_lvl;
            res.busy_res = 1'b1;
            if (tick_left_reg <= TICK_W'(1))
            begin
                unique case (phase_reg)
                    PH_HDR_MARK:
                    begin
                        phase_next     = PH_HDR_SPACE;
                        tick_left_next = TICK_W'(cfg.header_space_ticks);
                    end
                    PH_HDR_SPACE:
                    begin
                        bit_pos_next   = '0;
                        phase_next     = PH_BIT_MARK;
                        tick_left_next = TICK_W'(cfg.bit_mark_ticks);
                    end
                    PH_BIT_MARK:
                    begin
                        phase_next     = PH_BIT_SPACE;
                        tick_left_next = cur_bit ? TICK_W'(cfg.one_space_ticks)
                                                 : TICK_W'(cfg.zero_space_ticks);
                    end
                    PH_BIT_SPACE:
                    begin
                        phase_next     = ({1'b0, bit_pos_reg} >= LAST_POS) ? PH_FOOT_MARK
                                                                           : PH_BIT_MARK;
                        bit_pos_next   = ({1'b0, bit_pos_reg} >= LAST_POS) ? '0
                                                                           : bit_pos_reg + 1'b1;
                        tick_left_next = TICK_W'(cfg.bit_mark_ticks);
                    end
                    PH_FOOT_MARK:
                    begin
                        // first footer mark is followed by a header space, second by the gap
                        if (bit_pos_reg == '0)
                        begin
                            phase_next     = PH_FOOT_SPACE;
                            tick_left_next = TICK_W'(cfg.header_space_ticks);
                        end
                        else
                        begin
                            phase_next     = PH_GAP;
                            tick_left_next = cfg.gap_ticks;
                        end
                    end
                    PH_FOOT_SPACE:
                    begin
                        bit_pos_next   = POS_W'(1);
                        phase_next     = PH_FOOT_MARK;
                        tick_left_next = TICK_W'(cfg.bit_mark_ticks);
                    end
                    PH_GAP:
                    begin
                        bit_pos_next = '0;
                        if (repeats_reg != '0)
                        begin
                            repeats_next   = repeats_reg - 1'b1;
                            phase_next     = PH_HDR_MARK;
                            tick_left_next = TICK_W'(cfg.header_mark_ticks);
                        end
                        else
                        begin
                            phase_next     = PH_IDLE;
                            tick_left_next = '0;
                            res.done_res   = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            else
            begin
                tick_left_next = tick_left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_left_reg  <= '0;
            bit_pos_reg    <= '0;
            frame_word_reg <= '0;
            repeats_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            tick_left_reg  <= tick_left_next;
            bit_pos_reg    <= bit_pos_next;
            frame_word_reg <= frame_word_next;
            repeats_reg    <= repeats_next;
        end
    end

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done_res |=> phase_reg == PH_IDLE)
        else $error("done without return to idle");

    a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> tick_left_reg == '0)
        else $error("tick counter live while idle");

    a_foot_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FOOT_MARK || phase_reg == PH_FOOT_SPACE) |-> bit_pos_reg <= POS_W'(1))
        else $error("footer position out of range");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, bit_pos_reg} <= LAST_POS)
        else $error("bit position past end of frame");

endmodule
